// ===== src/scw_pkg.sv =====
package scw_pkg;

  localparam int LineCapacity = 32;

  localparam int AngleW = 8;
  localparam int TimeoutW = 16;
  localparam int ClkHzW = 27;
  localparam int TicksW = 18;
  localparam int RespW = 3;
  localparam int KindW = 4;
  localparam int AccW = 32;
  localparam int CfgIdxW = 3;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_PAN_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PAN_MAX = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TILT_MIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TILT_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PAN_CENTER = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TILT_CENTER = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CLK_HZ = 3'd7;

  // Response codes.
  localparam logic [RespW-1:0] RSP_ACK = 3'd0;
  localparam logic [RespW-1:0] RSP_CENTER = 3'd1;
  localparam logic [RespW-1:0] RSP_PAN = 3'd2;
  localparam logic [RespW-1:0] RSP_TILT = 3'd3;
  localparam logic [RespW-1:0] RSP_RANGE = 3'd4;
  localparam logic [RespW-1:0] RSP_ERROR = 3'd5;
  localparam logic [RespW-1:0] RSP_UNKNOWN = 3'd6;
  localparam logic [RespW-1:0] RSP_FAILSAFE = 3'd7;

  // Line classes.
  localparam logic [KindW-1:0] K_EMPTY = 4'd0;
  localparam logic [KindW-1:0] K_P = 4'd1;
  localparam logic [KindW-1:0] K_PING_PART = 4'd2;
  localparam logic [KindW-1:0] K_PING_FULL = 4'd3;
  localparam logic [KindW-1:0] K_PAN_PART = 4'd4;
  localparam logic [KindW-1:0] K_PAN_ARGS = 4'd5;
  localparam logic [KindW-1:0] K_C_PART = 4'd6;
  localparam logic [KindW-1:0] K_CENTER_FULL = 4'd7;
  localparam logic [KindW-1:0] K_T_PART = 4'd8;
  localparam logic [KindW-1:0] K_TILT_ARGS = 4'd9;
  localparam logic [KindW-1:0] K_OTHER = 4'd10;
  localparam logic [KindW-1:0] K_ARG_BAD = 4'd11;

  localparam logic [TicksW-1:0] TICK_MAX = '1;
  localparam logic [TicksW-1:0] PULSE_RESET = 18'd1875;

  // Which axes a conversion run updates.
  typedef struct packed {
    logic pan;
    logic tilt;
  } axis_sel_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic      start;     // latch angles and start conversion
    logic      use_acc;   // convert the accumulator instead of the centre angles
    axis_sel_t sel;       // axes to update
    logic      mul_step;  // register the clock-by-microsecond product
    logic      div_step;  // register the scaled quotient and write the pulse
  } dp_cmd_t;

  function automatic logic [7:0] center_char(input logic [2:0] n);
    case (n)
      3'd0: center_char = 8'h43;
      3'd1: center_char = 8'h45;
      3'd2: center_char = 8'h4E;
      3'd3: center_char = 8'h54;
      3'd4: center_char = 8'h45;
      3'd5: center_char = 8'h52;
      default: center_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tilt_char(input logic [2:0] n);
    case (n)
      3'd0: tilt_char = 8'h54;
      3'd1: tilt_char = 8'h49;
      3'd2: tilt_char = 8'h4C;
      3'd3: tilt_char = 8'h54;
      3'd4: tilt_char = 8'h20;
      default: tilt_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== src/scw_datapath.sv =====
module scw_datapath
  import scw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [AccW-1:0]     acc,
  input  logic [AngleW-1:0]   pan_center,
  input  logic [AngleW-1:0]   tilt_center,
  input  logic                pan_center_ok,
  input  logic                tilt_center_ok,
  input  logic [ClkHzW-1:0]   clk_hz,
  output logic [TicksW-1:0]   pan_ticks,
  output logic [TicksW-1:0]   tilt_ticks
);

  // 1/1e6 as a shift by 6, then a multiply by 2^45/15625 rounded up. The
  // reciprocal is exact for dividends below 2^32, which covers every product
  // that does not saturate; larger products are caught by a compare.
  localparam int ProdW = 39;
  localparam int RecipW = 32;
  localparam int RecipShift = 45;
  localparam logic [RecipW-1:0] RECIP = 32'd2251799814;
  localparam logic [ProdW-1:0] PROD_SAT = 39'd262144000000;

  logic [TicksW-1:0] pan_r, tilt_r;
  logic [11:0] us_pan_r, us_tilt_r;
  logic [ProdW-1:0] prod_pan_r, prod_tilt_r;
  logic [11:0] us_pan_nxt, us_tilt_nxt;
  logic [AngleW-1:0] ang_pan, ang_tilt;
  logic [63:0] q_pan, q_tilt;
  logic [TicksW-1:0] t_pan, t_tilt;

  // Angle to microseconds: 500 + angle*2000/180 = 500 + angle*100/9.
  function automatic logic [11:0] to_us(input logic [AngleW-1:0] a);
    logic [15:0] m;
    logic [15:0] q;
    m = 16'(a) * 16'd100;
    q = 16'((32'(m) * 32'd7282) >> 16);
    if (m - q * 16'd9 >= 16'd9) q = q + 16'd1;
    to_us = 12'(q) + 12'd500;
  endfunction

  always_comb begin
    ang_pan = cmd.use_acc ? acc[AngleW-1:0] : pan_center;
    ang_tilt = cmd.use_acc ? acc[AngleW-1:0] : tilt_center;
    us_pan_nxt = to_us(ang_pan);
    us_tilt_nxt = to_us(ang_tilt);
  end

  // Saturating scale of the registered product.
  always_comb begin
    q_pan = ({32'd0, prod_pan_r[37:6]} * {32'd0, RECIP}) >> RecipShift;
    q_tilt = ({32'd0, prod_tilt_r[37:6]} * {32'd0, RECIP}) >> RecipShift;
    t_pan = (prod_pan_r >= PROD_SAT) ? TICK_MAX : q_pan[TicksW-1:0];
    t_tilt = (prod_tilt_r >= PROD_SAT) ? TICK_MAX : q_tilt[TicksW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      us_pan_r <= us_pan_nxt;
      us_tilt_r <= us_tilt_nxt;
    end
    if (cmd.mul_step) begin
      prod_pan_r <= ProdW'(clk_hz) * ProdW'(us_pan_r);
      prod_tilt_r <= ProdW'(clk_hz) * ProdW'(us_tilt_r);
    end
  end

  // Pulse registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r <= PULSE_RESET;
      tilt_r <= PULSE_RESET;
    end else if (cmd.div_step) begin
      if (cmd.sel.pan && (cmd.use_acc || pan_center_ok)) pan_r <= t_pan;
      if (cmd.sel.tilt && (cmd.use_acc || tilt_center_ok)) tilt_r <= t_tilt;
    end
  end

  assign pan_ticks = pan_r;
  assign tilt_ticks = tilt_r;

endmodule

// ===== src/scw_ctrl.sv =====
module scw_ctrl
  import scw_pkg::*;
#(
  parameter int LINE_CAPACITY = LineCapacity
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RespW-1:0]    out_response,
  output logic                out_failsafe_on,
  input  logic [AngleW-1:0]   pan_min,
  input  logic [AngleW-1:0]   pan_max,
  input  logic [AngleW-1:0]   tilt_min,
  input  logic [AngleW-1:0]   tilt_max,
  input  logic [TimeoutW-1:0] timeout_ms,
  output dp_cmd_t             cmd,
  output logic [AccW-1:0]     acc
);

  localparam int LenW = $clog2(LINE_CAPACITY);
  localparam logic [LenW-1:0] LEN_LAST = LenW'(LINE_CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [KindW-1:0] kind_r, kind_nxt;
  logic cut_r, cut_nxt, dig_r, dig_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic [31:0] ms_r, ms_nxt;
  logic exp_r, exp_nxt, fs_r, fs_nxt;
  logic [RespW-1:0] resp_r, resp_nxt;
  logic use_acc_r, use_acc_nxt;
  axis_sel_t sel_r, sel_nxt;
  logic [31:0] ms_inc;
  logic is_digit;
  logic [7:0] dval;

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd.start = 1'b0;
    cmd.use_acc = use_acc_r;
    cmd.sel = sel_r;
    cmd.mul_step = (state_r == S_MUL);
    cmd.div_step = (state_r == S_DIV);
    state_nxt = state_r;
    len_nxt = len_r;
    kind_nxt = kind_r;
    cut_nxt = cut_r;
    dig_nxt = dig_r;
    acc_nxt = acc_r;
    ms_nxt = ms_r;
    exp_nxt = exp_r;
    fs_nxt = fs_r;
    resp_nxt = resp_r;
    use_acc_nxt = use_acc_r;
    sel_nxt = sel_r;
    ms_inc = (ms_r != '1) ? ms_r + 32'd1 : ms_r;
    is_digit = (in_rx_byte >= 8'h30) && (in_rx_byte <= 8'h39);
    dval = in_rx_byte - 8'h30;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op) begin
            // Millisecond tick and watchdog.
            ms_nxt = ms_inc;
            if (ms_inc >= 32'(timeout_ms)) exp_nxt = 1'b1;
            if ((exp_nxt) && !fs_r) begin
              fs_nxt = 1'b1;
              resp_nxt = RSP_FAILSAFE;
              use_acc_nxt = 1'b0;
              sel_nxt = '{pan: 1'b1, tilt: 1'b1};
              cmd.start = 1'b1;
              cmd.use_acc = 1'b0;
              state_nxt = S_MUL;
            end
          end else if (in_rx_byte == 8'h0D || in_rx_byte == 8'h0A) begin
            if (len_r != '0) begin
              // End of line: classify and act.
              len_nxt = '0; kind_nxt = K_EMPTY; cut_nxt = 1'b0;
              dig_nxt = 1'b0; acc_nxt = '0;
              sel_nxt = '{pan: 1'b0, tilt: 1'b0};
              use_acc_nxt = 1'b1;
              case (kind_r)
                K_PING_FULL: begin
                  resp_nxt = RSP_ACK;
                  ms_nxt = '0; exp_nxt = 1'b0; fs_nxt = 1'b0;
                  state_nxt = S_OUT;
                end
                K_CENTER_FULL: begin
                  resp_nxt = RSP_CENTER;
                  ms_nxt = '0; exp_nxt = 1'b0; fs_nxt = 1'b0;
                  use_acc_nxt = 1'b0;
                  sel_nxt = '{pan: 1'b1, tilt: 1'b1};
                  cmd.start = 1'b1;
                  cmd.use_acc = 1'b0;
                  state_nxt = S_MUL;
                end
                K_PAN_ARGS: begin
                  if (!dig_r) begin
                    resp_nxt = RSP_ERROR; state_nxt = S_OUT;
                  end else if (acc_r < 32'(pan_min) || acc_r > 32'(pan_max)) begin
                    resp_nxt = RSP_RANGE; state_nxt = S_OUT;
                  end else begin
                    resp_nxt = RSP_PAN;
                    ms_nxt = '0; exp_nxt = 1'b0; fs_nxt = 1'b0;
                    sel_nxt = '{pan: 1'b1, tilt: 1'b0};
                    cmd.start = 1'b1;
                    cmd.use_acc = 1'b1;
                    state_nxt = S_MUL;
                  end
                end
                K_TILT_ARGS: begin
                  if (!dig_r) begin
                    resp_nxt = RSP_ERROR; state_nxt = S_OUT;
                  end else if (acc_r < 32'(tilt_min) || acc_r > 32'(tilt_max)) begin
                    resp_nxt = RSP_RANGE; state_nxt = S_OUT;
                  end else begin
                    resp_nxt = RSP_TILT;
                    ms_nxt = '0; exp_nxt = 1'b0; fs_nxt = 1'b0;
                    sel_nxt = '{pan: 1'b0, tilt: 1'b1};
                    cmd.start = 1'b1;
                    cmd.use_acc = 1'b1;
                    state_nxt = S_MUL;
                  end
                end
                K_ARG_BAD: begin
                  resp_nxt = RSP_ERROR; state_nxt = S_OUT;
                end
                default: begin
                  resp_nxt = RSP_UNKNOWN; state_nxt = S_OUT;
                end
              endcase
            end
          end else if (len_r < LEN_LAST) begin
            // Ordinary byte: advance the line class.
            if (!cut_r) begin
              if (in_rx_byte == 8'h00) cut_nxt = 1'b1;
              else begin
                case (kind_r)
                  K_EMPTY: kind_nxt = (in_rx_byte == 8'h50) ? K_P :
                                      (in_rx_byte == 8'h43) ? K_C_PART :
                                      (in_rx_byte == 8'h54) ? K_T_PART : K_OTHER;
                  K_P: kind_nxt = (in_rx_byte == 8'h49) ? K_PING_PART :
                                  (in_rx_byte == 8'h41) ? K_PAN_PART : K_OTHER;
                  K_PING_PART: begin
                    if (len_r == LenW'(2) && in_rx_byte == 8'h4E) kind_nxt = K_PING_PART;
                    else if (len_r == LenW'(3) && in_rx_byte == 8'h47) kind_nxt = K_PING_FULL;
                    else kind_nxt = K_OTHER;
                  end
                  K_PAN_PART: begin
                    if (len_r == LenW'(2) && in_rx_byte == 8'h4E) kind_nxt = K_PAN_PART;
                    else if (len_r == LenW'(3) && in_rx_byte == 8'h20) kind_nxt = K_PAN_ARGS;
                    else kind_nxt = K_OTHER;
                  end
                  K_C_PART: begin
                    if (len_r < LenW'(6) && in_rx_byte == center_char(3'(len_r)))
                      kind_nxt = (len_r == LenW'(5)) ? K_CENTER_FULL : K_C_PART;
                    else kind_nxt = K_OTHER;
                  end
                  K_T_PART: begin
                    if (len_r < LenW'(5) && in_rx_byte == tilt_char(3'(len_r)))
                      kind_nxt = (len_r == LenW'(4)) ? K_TILT_ARGS : K_T_PART;
                    else kind_nxt = K_OTHER;
                  end
                  K_PAN_ARGS, K_TILT_ARGS: begin
                    if (is_digit) begin
                      acc_nxt = (acc_r << 3) + (acc_r << 1) + 32'(dval);
                      dig_nxt = 1'b1;
                    end else kind_nxt = K_ARG_BAD;
                  end
                  K_ARG_BAD: kind_nxt = K_ARG_BAD;
                  default: kind_nxt = K_OTHER;
                endcase
              end
            end
            len_nxt = len_r + LenW'(1);
          end else begin
            // Line too long.
            len_nxt = '0; kind_nxt = K_EMPTY; cut_nxt = 1'b0;
            dig_nxt = 1'b0; acc_nxt = '0;
            resp_nxt = RSP_ERROR;
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL: state_nxt = S_DIV;
      S_DIV: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= '0;
      kind_r <= K_EMPTY;
      cut_r <= 1'b0;
      dig_r <= 1'b0;
      acc_r <= '0;
      ms_r <= '0;
      exp_r <= 1'b0;
      fs_r <= 1'b0;
      resp_r <= RSP_ACK;
      use_acc_r <= 1'b0;
      sel_r <= '0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      kind_r <= kind_nxt;
      cut_r <= cut_nxt;
      dig_r <= dig_nxt;
      acc_r <= acc_nxt;
      ms_r <= ms_nxt;
      exp_r <= exp_nxt;
      fs_r <= fs_nxt;
      resp_r <= resp_nxt;
      use_acc_r <= use_acc_nxt;
      sel_r <= sel_nxt;
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_response = resp_r;
  assign out_failsafe_on = fs_r;
  assign acc = acc_r;

endmodule

// ===== src/servo_command_watchdog_core.sv =====
// Status-only responses are registered straight into the output state; when the pulse
// widths are recomputed, the word first passes the multiply stage then the scale stage.
// One word at a time: a word that gives no result is taken without stalling the input;
// otherwise the input stalls until the result has been taken, including any output stall.
// Reset (rst_n low, synchronous) restores register defaults, clears the line and
// the watchdog, and sets both pulses to 1875 ticks.
module servo_command_watchdog_core
  import scw_pkg::*;
#(
  parameter int LINE_CAPACITY = LineCapacity
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RespW-1:0]    out_response,
  output logic [TicksW-1:0]   out_pan_ticks,
  output logic [TicksW-1:0]   out_tilt_ticks,
  output logic                out_failsafe_on,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [ClkHzW-1:0]   cfg_data
);

  logic [AngleW-1:0] pan_min_r, pan_max_r, tilt_min_r, tilt_max_r;
  logic [AngleW-1:0] pan_ctr_r, tilt_ctr_r;
  logic [TimeoutW-1:0] timeout_r;
  logic [ClkHzW-1:0] clk_hz_r;
  dp_cmd_t cmd;
  logic [AccW-1:0] acc;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_min_r <= 8'd45;
      pan_max_r <= 8'd135;
      tilt_min_r <= 8'd55;
      tilt_max_r <= 8'd125;
      pan_ctr_r <= 8'd90;
      tilt_ctr_r <= 8'd90;
      timeout_r <= 16'd300;
      clk_hz_r <= 27'd1250000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAN_MIN: pan_min_r <= cfg_data[AngleW-1:0];
        REG_PAN_MAX: pan_max_r <= cfg_data[AngleW-1:0];
        REG_TILT_MIN: tilt_min_r <= cfg_data[AngleW-1:0];
        REG_TILT_MAX: tilt_max_r <= cfg_data[AngleW-1:0];
        REG_PAN_CENTER: pan_ctr_r <= cfg_data[AngleW-1:0];
        REG_TILT_CENTER: tilt_ctr_r <= cfg_data[AngleW-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data[TimeoutW-1:0];
        REG_CLK_HZ: clk_hz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  scw_ctrl #(.LINE_CAPACITY(LINE_CAPACITY)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_rx_byte,
    .out_valid, .out_stall, .out_response, .out_failsafe_on,
    .pan_min(pan_min_r), .pan_max(pan_max_r),
    .tilt_min(tilt_min_r), .tilt_max(tilt_max_r),
    .timeout_ms(timeout_r), .cmd, .acc
  );

  scw_datapath u_dp (
    .clk, .rst_n, .cmd, .acc,
    .pan_center(pan_ctr_r), .tilt_center(tilt_ctr_r),
    .pan_center_ok(pan_ctr_r >= pan_min_r && pan_ctr_r <= pan_max_r),
    .tilt_center_ok(tilt_ctr_r >= tilt_min_r && tilt_ctr_r <= tilt_max_r),
    .clk_hz(clk_hz_r),
    .pan_ticks(out_pan_ticks), .tilt_ticks(out_tilt_ticks)
  );

endmodule

// ===== src/scw_checker.sv =====
module scw_checker
  import scw_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [RespW-1:0]  out_response,
  input logic              out_failsafe_on
);

  // A failsafe word always reports the flag set.
  a_fs_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_response == RSP_FAILSAFE |-> out_failsafe_on)
    else $error("failsafe response without flag");

  // Successful commands clear the flag.
  a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_response == RSP_ACK || out_response == RSP_PAN ||
                  out_response == RSP_TILT || out_response == RSP_CENTER)
    |-> !out_failsafe_on)
    else $error("command did not clear failsafe");

  // No new word is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // A pending result holds under stall.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_response))
    else $error("result changed under stall");

endmodule

bind servo_command_watchdog_core scw_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_response, .out_failsafe_on
);
